### design/pwn_pkg.sv
// Shared types and constants for the point-in-polygon winding block.
`timescale 1ns / 1ps

package pwn_pkg;

    // Fixed widths of the interface fields.
    localparam int RAW_W       = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int WIND_W      = 8;

    // A polygon needs at least this many vertices.
    localparam logic [COUNT_W-1:0] MIN_VERTS = 8'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_X   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_Y   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILL_RULE = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_FEW  = 2'd1,
        STATUS_TOO_MANY = 2'd2
    } status_t;

    // Contribution of one edge to the winding count: none, plus one or minus one.
    typedef struct packed {
        logic hit;
        logic neg;
    } edge_step_t;

    // Load enables for the two register stages of an edge test.
    typedef struct packed {
        logic load_mul;
        logic load_dec;
    } edge_en_t;

    // Control carried with a vertex beat out of the input stage.
    typedef struct packed {
        logic    has_prev;
        logic    fin;
        status_t status;
    } front_flags_t;

endpackage

### design/pwn_front.sv
// Input stage: captures a vertex beat and tracks the first and previous vertex.
`timescale 1ns / 1ps

module pwn_front
    import pwn_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int MAX_VERTS  = 128
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic signed [RAW_W-1:0]      vertex_x,
    input  logic signed [RAW_W-1:0]      vertex_y,
    input  logic                         final_vertex,
    input  logic [RAW_W-1:0]             probe_x,
    input  logic [RAW_W-1:0]             probe_y,
    output logic signed [COORD_BITS-1:0] cur_x,
    output logic signed [COORD_BITS-1:0] cur_y,
    output logic signed [COORD_BITS-1:0] prev_x,
    output logic signed [COORD_BITS-1:0] prev_y,
    output logic signed [COORD_BITS-1:0] first_x,
    output logic signed [COORD_BITS-1:0] first_y,
    output logic signed [COORD_BITS-1:0] px,
    output logic signed [COORD_BITS-1:0] py,
    output front_flags_t                 flags
);

    localparam logic [COUNT_W-1:0] MaxVerts  = COUNT_W'(MAX_VERTS);
    localparam logic [COUNT_W-1:0] CountFull = {COUNT_W{1'b1}};

    // Keep the low COORD_BITS of a zero-extended 16-bit value; the top kept bit
    // is the sign, so widths above 16 read the field as unsigned.
    function automatic logic signed [COORD_BITS-1:0] to_coord(input logic [RAW_W-1:0] raw);
        logic [31:0] ext;
        ext = {16'b0, raw};
        return ext[COORD_BITS-1:0];
    endfunction

    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] last_x_reg, last_y_reg;
    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] first_out_x_reg, first_out_y_reg;
    front_flags_t                 flags_reg;
    front_flags_t                 flags_next;

    assign vx = to_coord(vertex_x);
    assign vy = to_coord(vertex_y);
    assign px = to_coord(probe_x);
    assign py = to_coord(probe_y);

    // Vertex count saturates and decides the status of a closing beat.
    always_comb
    begin
        count_next = (count_reg == CountFull) ? count_reg : count_reg + 1'b1;
        flags_next.has_prev = (count_reg != '0);
        flags_next.fin      = final_vertex;
        if (count_next > MaxVerts)
        begin
            flags_next.status = STATUS_TOO_MANY;
        end
        else if (count_next < MIN_VERTS)
        begin
            flags_next.status = STATUS_TOO_FEW;
        end
        else
        begin
            flags_next.status = STATUS_OK;
        end
    end

    // Polygon tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end
        else if (take)
        begin
            count_reg  <= final_vertex ? '0 : count_next;
            last_x_reg <= vx;
            last_y_reg <= vy;
            if (count_reg == '0)
            begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
        end
    end

    // Stage register handed to the edge tests.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_x_reg       <= vx;
            cur_y_reg       <= vy;
            prev_x_reg      <= last_x_reg;
            prev_y_reg      <= last_y_reg;
            first_out_x_reg <= (count_reg == '0) ? vx : first_x_reg;
            first_out_y_reg <= (count_reg == '0) ? vy : first_y_reg;
            flags_reg       <= flags_next;
        end
    end

    assign cur_x   = cur_x_reg;
    assign cur_y   = cur_y_reg;
    assign prev_x  = prev_x_reg;
    assign prev_y  = prev_y_reg;
    assign first_x = first_out_x_reg;
    assign first_y = first_out_y_reg;
    assign flags   = flags_reg;

endmodule

### design/pwn_edge.sv
// One edge crossing test: products in one stage, cross product sign in the next.
`timescale 1ns / 1ps

module pwn_edge
    import pwn_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  edge_en_t                     ctl,
    input  logic                         en,
    input  logic signed [COORD_BITS-1:0] a_x,
    input  logic signed [COORD_BITS-1:0] a_y,
    input  logic signed [COORD_BITS-1:0] b_x,
    input  logic signed [COORD_BITS-1:0] b_y,
    input  logic signed [COORD_BITS-1:0] px,
    input  logic signed [COORD_BITS-1:0] py,
    output edge_step_t                   step
);

    localparam int DiffW  = COORD_BITS + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int CrossW = ProdW + 1;

    logic signed [DiffW-1:0]  dax, day, dbx, dby;
    logic signed [ProdW-1:0]  prod_a, prod_b;
    logic signed [ProdW-1:0]  prod_a_reg, prod_b_reg;
    logic                     counts_reg, upper_reg, xa_reg, xb_reg;
    logic signed [CrossW-1:0] cross_sum;
    edge_step_t               step_next;
    edge_step_t               step_reg;

    // Offsets from the probe and along the edge, then the two products.
    always_comb
    begin
        dax    = DiffW'(a_x) - DiffW'(px);
        day    = DiffW'(a_y) - DiffW'(py);
        dbx    = DiffW'(b_x) - DiffW'(a_x);
        dby    = DiffW'(b_y) - DiffW'(a_y);
        prod_a = ProdW'(dax) * ProdW'(dby);
        prod_b = ProdW'(day) * ProdW'(dbx);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mul)
        begin
            prod_a_reg <= prod_a;
            prod_b_reg <= prod_b;
            counts_reg <= en && ((a_y >= py) != (b_y >= py));
            upper_reg  <= (a_y >= py);
            xa_reg     <= (a_x >= px);
            xb_reg     <= (b_x >= px);
        end
    end

    // A downward edge (upper start) counts minus one, an upward edge plus one.
    always_comb
    begin
        cross_sum     = CrossW'(prod_a_reg) - CrossW'(prod_b_reg);
        step_next.neg = upper_reg;
        step_next.hit = 1'b0;
        if (counts_reg)
        begin
            if (xa_reg == xb_reg)
            begin
                step_next.hit = xa_reg;
            end
            else if (!upper_reg)
            begin
                step_next.hit = !cross_sum[CrossW-1];
            end
            else
            begin
                step_next.hit = cross_sum[CrossW-1] || (cross_sum == '0);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (ctl.load_dec)
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule

### design/pwn_accum.sv
// Saturating winding accumulator and result register.
`timescale 1ns / 1ps

module pwn_accum
    import pwn_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic                     fin,
    input  status_t                  st,
    input  edge_step_t               d_open,
    input  edge_step_t               d_close,
    input  logic                     fill_rule,
    input  logic                     out_stall,
    output logic                     ready,
    output logic                     out_valid,
    output logic signed [WIND_W-1:0] winding,
    output logic                     inside_res,
    output logic [1:0]               status
);

    localparam logic signed [WIND_W-1:0] WindMax = {1'b0, {(WIND_W-1){1'b1}}};
    localparam logic signed [WIND_W-1:0] WindMin = {1'b1, {(WIND_W-1){1'b0}}};

    // Add one edge step, holding at the ends of the range.
    function automatic logic signed [WIND_W-1:0] sat_step(input logic signed [WIND_W-1:0] s,
                                                          input edge_step_t d);
        if (!d.hit)
        begin
            return s;
        end
        else if (d.neg)
        begin
            return (s == WindMin) ? s : s - 1'b1;
        end
        return (s == WindMax) ? s : s + 1'b1;
    endfunction

    logic signed [WIND_W-1:0] sum_reg;
    logic signed [WIND_W-1:0] sum_open, sum_next;
    logic                     out_valid_reg;
    logic signed [WIND_W-1:0] winding_reg;
    logic                     inside_reg;
    status_t                  status_reg;

    always_comb
    begin
        sum_open = sat_step(sum_reg, d_open);
        sum_next = sat_step(sum_open, d_close);
    end

    assign ready = !out_valid_reg || !out_stall;

    // Running sum and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                sum_reg <= fin ? '0 : sum_next;
            end
            if (take && fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; a bad status reports no winding.
    always_ff @(posedge clk)
    begin
        if (take && fin)
        begin
            status_reg <= st;
            if (st == STATUS_OK)
            begin
                winding_reg <= sum_next;
                inside_reg  <= fill_rule ? (sum_next != '0) : sum_next[0];
            end
            else
            begin
                winding_reg <= '0;
                inside_reg  <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign winding    = winding_reg;
    assign inside_res = inside_reg;
    assign status     = status_reg;

endmodule

### design/point_in_polygon_winding.sv
// Top level of the winding-number point-in-polygon tester.
`timescale 1ns / 1ps

// Polygon vertices arrive one beat at a time, the last one flagged by final_vertex,
// and the probe point and fill rule come from the configuration port. The block takes
// one vertex every cycle while in_stall is low. A polygon's result passes through the
// input register, loaded at the accepting edge, then the multiply stage and the cross
// product sign stage of both edge tests (the open edge from the previous vertex and
// the closing edge back to the first), and the saturating accumulator that loads the
// result register. Only a final vertex waits for room in the result register; while it
// waits at the last edge stage, the two vertices behind it fill the stages in front and
// the input then stalls. Status reports too few vertices (under three) or more than
// MAX_VERTS vertices, with winding and inside forced to zero. There is no start-up
// clearing: the block is ready straight after reset.
module point_in_polygon_winding
    import pwn_pkg::*;
#(
    parameter int MAX_VERTS  = 128,
    parameter int COORD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [RAW_W-1:0]  vertex_x,
    input  logic signed [RAW_W-1:0]  vertex_y,
    input  logic                     final_vertex,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WIND_W-1:0] winding,
    output logic                     inside_res,
    output logic [1:0]               status,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data
);

    logic [RAW_W-1:0] probe_x_reg, probe_y_reg;
    logic             fill_rule_reg;

    logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y, first_x, first_y, px, py;
    front_flags_t                 flags;

    logic       v1_reg, v2_reg, v3_reg;
    logic       fin2_reg, fin3_reg;
    status_t    st2_reg, st3_reg;
    logic       take1, adv12, adv23, take3;
    logic       ready4;
    edge_en_t   edge_ctl;
    edge_step_t d_open, d_close;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_x_reg   <= '0;
            probe_y_reg   <= '0;
            fill_rule_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROBE_X:   probe_x_reg   <= cfg_data[RAW_W-1:0];
                REG_PROBE_Y:   probe_y_reg   <= cfg_data[RAW_W-1:0];
                REG_FILL_RULE: fill_rule_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Pipeline flow: only a final beat needs room in the result register.
    always_comb
    begin
        take3    = v3_reg && (!fin3_reg || ready4);
        adv23    = v2_reg && (!v3_reg || take3);
        adv12    = v1_reg && (!v2_reg || adv23);
        in_stall = v1_reg && !adv12;
        take1    = in_valid && !in_stall;
        edge_ctl.load_mul = adv12;
        edge_ctl.load_dec = adv23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take1 || (v1_reg && !adv12);
            v2_reg <= adv12 || (v2_reg && !adv23);
            v3_reg <= adv23 || (v3_reg && !take3);
        end
    end

    // Beat control travelling alongside the edge tests.
    always_ff @(posedge clk)
    begin
        if (adv12)
        begin
            fin2_reg <= flags.fin;
            st2_reg  <= flags.status;
        end
        if (adv23)
        begin
            fin3_reg <= fin2_reg;
            st3_reg  <= st2_reg;
        end
    end

    pwn_front #(
        .COORD_BITS (COORD_BITS),
        .MAX_VERTS  (MAX_VERTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take1),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .final_vertex (final_vertex),
        .probe_x      (probe_x_reg),
        .probe_y      (probe_y_reg),
        .cur_x        (cur_x),
        .cur_y        (cur_y),
        .prev_x       (prev_x),
        .prev_y       (prev_y),
        .first_x      (first_x),
        .first_y      (first_y),
        .px           (px),
        .py           (py),
        .flags        (flags)
    );

    // Edge from the previous vertex to this one.
    pwn_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_open (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (edge_ctl),
        .en    (flags.has_prev),
        .a_x   (prev_x),
        .a_y   (prev_y),
        .b_x   (cur_x),
        .b_y   (cur_y),
        .px    (px),
        .py    (py),
        .step  (d_open)
    );

    // Closing edge from the final vertex back to the first.
    pwn_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge_close (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (edge_ctl),
        .en    (flags.fin),
        .a_x   (cur_x),
        .a_y   (cur_y),
        .b_x   (first_x),
        .b_y   (first_y),
        .px    (px),
        .py    (py),
        .step  (d_close)
    );

    pwn_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take3),
        .fin        (fin3_reg),
        .st         (st3_reg),
        .d_open     (d_open),
        .d_close    (d_close),
        .fill_rule  (fill_rule_reg),
        .out_stall  (out_stall),
        .ready      (ready4),
        .out_valid  (out_valid),
        .winding    (winding),
        .inside_res (inside_res),
        .status     (status)
    );

`ifndef SYNTH
    // An empty result register never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall)
        else $error("input stalled while the result register is empty");

    // A result appears only when a final beat leaves the last edge stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(take3 && fin3_reg))
        else $error("result beat without a final vertex behind it");

    // A failed polygon reports neither winding nor inside.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (winding == '0) && !inside_res)
        else $error("bad status with a non-zero result");
`endif

endmodule

### tb/winding_result_check.sv
// Checker that predicts and compares the result beats of the winding-number block.
`timescale 1ns / 1ps

// Watches the vertex, result and configuration ports. Every accepted vertex beat
// goes through a shadow model of the winding count. Every accepted result beat is
// compared field by field with the oldest predicted polygon result.
module winding_result_check
    import pwn_pkg::*;
#(
    parameter int MAX_VERTS  = 128,
    parameter int COORD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [RAW_W-1:0]         vertex_x,
    input  logic [RAW_W-1:0]         vertex_y,
    input  logic                     final_vertex,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [WIND_W-1:0] winding,
    input  logic                     inside_res,
    input  logic [1:0]               status,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    output int                       mismatches,
    output int                       outstanding,
    output int                       results_checked
);

    // Expected content of one result beat.
    typedef struct packed {
        logic signed [WIND_W-1:0] winding;
        logic                     inner;
        status_t                  status;
    } polygon_verdict_t;

    // Shadow copy of the configuration registers.
    logic [RAW_W-1:0] probe_x_reg;
    logic [RAW_W-1:0] probe_y_reg;
    logic             fill_nonzero;

    // Shadow copy of the polygon being accumulated.
    longint first_x;
    longint first_y;
    longint prev_x;
    longint prev_y;
    int     winding_sum;
    int     vertex_count;

    polygon_verdict_t expected_verdicts[$];

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Reads the low COORD_BITS of a raw field as a signed coordinate.
    function automatic longint coord_value(input logic [RAW_W-1:0] raw);
        longint span;
        longint v;
        span = longint'(1) << COORD_BITS;
        v = longint'(raw) & (span - 1);
        if (v >= span / 2)
            v = v - span;
        return v;
    endfunction

    // Contribution of the edge a -> b to the winding count around the probe.
    function automatic int crossing_step(input longint ax, input longint ay,
                                         input longint bx, input longint by);
        longint px;
        longint py;
        longint cross_prod;
        logic   upper;
        logic   a_right;
        logic   b_right;
        int     dir;
        px = coord_value(probe_x_reg);
        py = coord_value(probe_y_reg);
        upper = (ay >= py);
        // Only an edge that crosses the probe's row can count.
        if (upper == (by >= py))
            return 0;
        dir = upper ? -1 : 1;
        a_right = (ax >= px);
        b_right = (bx >= px);
        // Both ends on one side of the probe's column: only the right side counts.
        if (a_right == b_right)
            return a_right ? dir : 0;
        // Straddling edge: decided by the side of the probe, a zero cross product counts.
        cross_prod = (ax - px) * (by - ay) - (ay - py) * (bx - ax);
        if ((dir > 0 && cross_prod >= 0) || (dir < 0 && cross_prod <= 0))
            return dir;
        return 0;
    endfunction

    // Adds one edge step to the running sum, saturating at the 8-bit limits.
    task automatic add_step(input int step);
        winding_sum = winding_sum + step;
        if (winding_sum > 127)
            winding_sum = 127;
        if (winding_sum < -128)
            winding_sum = -128;
    endtask

    // Takes one vertex into the running polygon; on the final vertex it closes the
    // polygon and queues the expected result.
    task automatic absorb_vertex(input logic [RAW_W-1:0] raw_x, input logic [RAW_W-1:0] raw_y,
                                 input logic fin);
        longint           x;
        longint           y;
        polygon_verdict_t v;
        x = coord_value(raw_x);
        y = coord_value(raw_y);
        if (vertex_count == 0)
        begin
            first_x = x;
            first_y = y;
        end
        else
        begin
            add_step(crossing_step(prev_x, prev_y, x, y));
        end
        prev_x = x;
        prev_y = y;
        if (vertex_count < 255)
            vertex_count++;
        if (fin)
        begin
            add_step(crossing_step(x, y, first_x, first_y));
            v.winding = '0;
            v.inner   = 1'b0;
            v.status  = STATUS_OK;
            if (vertex_count > MAX_VERTS)
                v.status = STATUS_TOO_MANY;
            else if (vertex_count < int'(MIN_VERTS))
                v.status = STATUS_TOO_FEW;
            else
            begin
                v.winding = WIND_W'(winding_sum);
                v.inner   = fill_nonzero ? (winding_sum != 0) : winding_sum[0];
            end
            expected_verdicts.push_back(v);
            winding_sum  = 0;
            vertex_count = 0;
        end
    endtask

    // Sample all channels at the clock edge; results are checked before new vertices.
    always @(posedge clk or negedge rst_n)
    begin
        polygon_verdict_t want;
        if (!rst_n)
        begin
            probe_x_reg     = '0;
            probe_y_reg     = '0;
            fill_nonzero    = 1'b0;
            first_x         = 0;
            first_y         = 0;
            prev_x          = 0;
            prev_y          = 0;
            winding_sum     = 0;
            vertex_count    = 0;
            mismatches      = 0;
            results_checked = 0;
            expected_verdicts.delete();
            outstanding    <= 0;
        end
        else
        begin
            // Result beat: compare with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result beat, winding %0d status %0d",
                                            winding, status));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    results_checked++;
                    if (winding !== want.winding)
                        flag_mismatch($sformatf("winding %0d, expected %0d",
                                                winding, want.winding));
                    if (inside_res !== want.inner)
                        flag_mismatch($sformatf("inside_res %0b, expected %0b",
                                                inside_res, want.inner));
                    if (status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %s",
                                                status, want.status.name()));
                end
            end

            // Register writes update the shadow configuration.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROBE_X:   probe_x_reg  = cfg_data[RAW_W-1:0];
                    REG_PROBE_Y:   probe_y_reg  = cfg_data[RAW_W-1:0];
                    REG_FILL_RULE: fill_nonzero = cfg_data[0];
                    default: ;
                endcase
            end

            // Vertex beat: advance the shadow winding count.
            if (in_valid && !in_stall)
                absorb_vertex(vertex_x, vertex_y, final_vertex);

            outstanding <= expected_verdicts.size();
        end
    end

endmodule

### tb/point_in_polygon_winding_test.sv
// Top of the testbench for the winding-number point-in-polygon block.
`timescale 1ns / 1ps

// Drives polygons through the block under a series of probe and fill-rule settings,
// with random gaps on both channels and one long output hold-off; the checker beside
// the block predicts every result and counts mismatches.
module point_in_polygon_winding_test;
    import pwn_pkg::*;

    localparam int MAX_VERTS   = 128;
    localparam int COORD_BITS  = 16;
    localparam int LIMIT       = 200000;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 110;

    typedef enum int {
        SHAPE_SCATTER,
        SHAPE_ORBIT,
        SHAPE_WILD
    } shape_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [RAW_W-1:0]  vertex_x;
    logic signed [RAW_W-1:0]  vertex_y;
    logic                     final_vertex;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WIND_W-1:0] winding;
    logic                     inside_res;
    logic [1:0]               status;
    logic                     cfg_we;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    int mismatches;
    int outstanding;
    int results_checked;

    bit sender_idles;
    bit receiver_idles;
    bit hold_request;
    int cycles;

    logic signed [RAW_W-1:0] probe_x_now;
    logic signed [RAW_W-1:0] probe_y_now;

    int vertices_sent;
    int polygons_sent;
    int few_sent;
    int many_sent;
    int settings_written;

    point_in_polygon_winding #(
        .MAX_VERTS  (MAX_VERTS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .final_vertex (final_vertex),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .winding      (winding),
        .inside_res   (inside_res),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    winding_result_check #(
        .MAX_VERTS  (MAX_VERTS),
        .COORD_BITS (COORD_BITS)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .final_vertex    (final_vertex),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .winding         (winding),
        .inside_res      (inside_res),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // 8 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial
    begin
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= receiver_idles && ($urandom_range(99) < 35);
            end
        end
    end

    // Offers one vertex beat, after a random gap while sender_idles is set, and waits until it is taken.
    task automatic send_vertex(input logic signed [RAW_W-1:0] x,
                               input logic signed [RAW_W-1:0] y, input logic fin);
        while (sender_idles && ($urandom_range(99) < 35))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        vertex_x     <= x;
        vertex_y     <= y;
        final_vertex <= fin;
        do
            @(posedge clk);
        while (in_stall);
        vertices_sent++;
    endtask

    // A coordinate mostly close to the probe, sometimes anywhere or at an extreme.
    function automatic logic signed [RAW_W-1:0] pick_coord(
        input logic signed [RAW_W-1:0] centre);
        int                      mode;
        logic signed [RAW_W-1:0] c;
        mode = $urandom_range(99);
        if (mode < 45)
            c = RAW_W'(int'(centre) + int'($urandom_range(12)) - 6);
        else if (mode < 75)
            c = RAW_W'(int'(centre) + int'($urandom_range(1000)) - 500);
        else if (mode < 90)
            c = RAW_W'($urandom);
        else
        begin
            case ($urandom_range(2))
                0:       c = RAW_W'(-32768);
                1:       c = RAW_W'(32767);
                default: c = centre;
            endcase
        end
        return c;
    endfunction

    // Sends one polygon of the given length, the last vertex flagged.
    task automatic send_polygon(input int count, input shape_t shape);
        int                      i;
        int                      corner;
        int                      reach;
        bit                      ccw;
        logic signed [RAW_W-1:0] x;
        logic signed [RAW_W-1:0] y;
        ccw = 1'($urandom_range(1));
        polygons_sent++;
        if (count < 3)
            few_sent++;
        if (count > MAX_VERTS)
            many_sent++;
        for (i = 0; i < count; i++)
        begin
            case (shape)
                SHAPE_ORBIT:
                begin
                    // Walk the corners of a square around the probe, one corner per
                    // vertex, so that each lap adds a turn in the chosen direction.
                    corner = ccw ? (i % 4) : (3 - i % 4);
                    reach  = ($urandom_range(15) == 0) ? 0 : $urandom_range(3000, 1);
                    x = RAW_W'(int'(probe_x_now) + ((corner < 2) ? reach : -reach));
                    y = RAW_W'(int'(probe_y_now)
                               + ((corner == 1 || corner == 2) ? reach : -reach));
                end
                SHAPE_WILD:
                begin
                    x = RAW_W'($urandom);
                    y = RAW_W'($urandom);
                end
                default:
                begin
                    x = pick_coord(probe_x_now);
                    y = pick_coord(probe_y_now);
                end
            endcase
            send_vertex(x, y, i == count - 1);
        end
    endtask

    // Writes all three registers on consecutive cycles.
    task automatic configure(input logic signed [RAW_W-1:0] px,
                             input logic signed [RAW_W-1:0] py, input logic fill);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROBE_X;
        cfg_data  <= px;
        @(posedge clk);
        cfg_index <= REG_PROBE_Y;
        cfg_data  <= py;
        @(posedge clk);
        cfg_index <= REG_FILL_RULE;
        cfg_data  <= {(CFG_DATA_W-1)'($urandom), fill};
        @(posedge clk);
        cfg_we <= 1'b0;
        probe_x_now = px;
        probe_y_now = py;
        settings_written++;
    endtask

    // Stops offering vertices, waits for every predicted result, then lets the
    // pipeline empty of vertices that produce no result.
    task automatic settle_block();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int phase;
        int start;
        int pick;
        int i;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        vertex_x     <= '0;
        vertex_y     <= '0;
        final_vertex <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_PROBE_X;
        cfg_data     <= '0;
        probe_x_now   = '0;
        probe_y_now   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // Directed polygons, first under the register values left by reset.
        // Counter-clockwise triangle around the probe.
        send_vertex(-100, -100, 1'b0);
        send_vertex(100, -100, 1'b0);
        send_vertex(0, 100, 1'b1);
        // A lone vertex and a two-vertex polygon are too short.
        send_vertex(0, 0, 1'b1);
        send_vertex(32767, 32767, 1'b0);
        send_vertex(-32768, -32768, 1'b1);
        // Probe lying exactly on an edge, with a horizontal edge on the probe's row.
        send_vertex(-10, 0, 1'b0);
        send_vertex(10, 0, 1'b0);
        send_vertex(0, 10, 1'b1);
        // Triangle spanning the whole coordinate range.
        send_vertex(-32768, -32768, 1'b0);
        send_vertex(32767, -32768, 1'b0);
        send_vertex(32767, 32767, 1'b1);

        // Nonzero rule: a square wound twice, then a clockwise triangle.
        settle_block();
        configure(0, 0, 1'b1);
        for (i = 0; i < 8; i++)
            send_vertex((i % 4 < 2) ? 5 : -5, (i % 4 == 1 || i % 4 == 2) ? 5 : -5, i == 7);
        send_vertex(0, 100, 1'b0);
        send_vertex(100, -100, 1'b0);
        send_vertex(-100, -100, 1'b1);

        // Random polygons over a series of register settings.
        for (phase = 0; phase < 8; phase++)
        begin
            settle_block();
            case (phase)
                0:       configure(0, 0, 1'b0);
                1:       configure(-32768, -32768, 1'b1);
                2:       configure(32767, 32767, 1'b0);
                6:       configure(32767, -32768, 1'($urandom));
                default: configure(RAW_W'($urandom), RAW_W'($urandom), 1'($urandom));
            endcase
            // Phase 3 runs with no idling at all; phase 4 holds the result side off
            // while triangles keep coming, so the block fills up.
            sender_idles   = (phase != 3 && phase != 4);
            receiver_idles = (phase != 3);
            if (phase == 4)
                hold_request = 1'b1;
            // Around the vertex limit, and past the point where the count saturates.
            if (phase == 5)
            begin
                send_polygon(MAX_VERTS, SHAPE_ORBIT);
                send_polygon(MAX_VERTS + 1, SHAPE_ORBIT);
                send_polygon(260, SHAPE_ORBIT);
            end
            start = vertices_sent;
            while (vertices_sent - start < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (phase == 4)
                    send_polygon(3, SHAPE_ORBIT);
                else if (pick < 12)
                    send_polygon($urandom_range(2, 1), SHAPE_SCATTER);
                else if (pick < 45)
                    send_polygon($urandom_range(10, 3), SHAPE_SCATTER);
                else if (pick < 82)
                    send_polygon($urandom_range(16, 3), SHAPE_ORBIT);
                else
                    send_polygon($urandom_range(8, 3), SHAPE_WILD);
            end
        end

        settle_block();
        $display("Sent %0d vertices in %0d polygons (%0d too short, %0d over the limit);",
                 vertices_sent, polygons_sent, few_sent, many_sent);
        $display("%0d results compared over %0d register settings, both fill rules.",
                 results_checked, settings_written);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
